### design/srtf_pkg.sv
`timescale 1ns / 1ps
package srtf_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] CNT_MAX = 16'hFFFF;

	localparam logic CMD_JOB = 1'b0;
	localparam logic CMD_END = 1'b1;

	typedef struct packed {
		logic        command;
		logic [15:0] job_id;
		logic [31:0] arrive_time;
		logic [15:0] burst;
	} in_word_t;

	typedef struct packed {
		logic [15:0] done_id;
		logic [31:0] finish_time;
		logic [31:0] turnaround;
		logic        is_summary;
		logic [47:0] turnaround_sum;
		logic [15:0] jobs_done;
		logic        overflow;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic        load_in;
		logic        scan_clear;
		logic        scan_step;
		logic        start_clock;
		logic        clamp_arrival;
		logic        complete;
		logic        drain_mode;
		logic        preempt;
		logic        jump_clock;
		logic        insert;
		logic        mark_overflow;
		logic        emit_job;
		logic        emit_summary;
		logic        emit_last;
		logic        clear_all;
	} dp_cmd_t;

	typedef struct packed {
		logic        is_end;
		logic        started;
		logic        scan_done;
		logic        found;
		logic        before_arrival;
		logic        ends_by_arrival;
		logic        any_valid;
		logic        out_busy;
	} dp_sts_t;

endpackage

### design/srtf_datapath.sv
`timescale 1ns / 1ps
module srtf_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  srtf_pkg::in_word_t  in_word,
	input  srtf_pkg::dp_cmd_t   cmd,
	output srtf_pkg::dp_sts_t   sts,
	output srtf_pkg::out_word_t out_word,
	input  logic                out_busy
);
	localparam int D = srtf_pkg::QUEUE_DEPTH;
	localparam int W = srtf_pkg::IDX_W;

	logic [15:0] id_q [D];
	logic [31:0] arr_q [D];
	logic [15:0] rem_q [D];
	logic [15:0] age_q [D];
	logic [D-1:0] valid_q;

	srtf_pkg::in_word_t in_q;
	logic [31:0] clock_q;
	logic        started_q;
	logic [47:0] sum_q;
	logic [15:0] cnt_q;
	logic        ovf_q;
	logic [31:0] arr_eff_q;

	logic [W:0]   scan_q;
	logic         found_q;
	logic [W-1:0] best_q;
	logic [15:0]  brem_q;
	logic [15:0]  bage_q;

	logic [W-1:0] sidx;
	logic         better;
	logic [32:0]  end_w;
	logic [31:0]  fin;
	logic [31:0]  ta;
	logic [48:0]  sum_n;
	logic [47:0]  sum_sat;
	logic [15:0]  cnt_inc;
	logic [W-1:0] free_idx;
	logic         has_free;

	assign sidx = scan_q[W-1:0];
	assign better = valid_q[sidx] && (!found_q || rem_q[sidx] < brem_q ||
		(rem_q[sidx] == brem_q && age_q[sidx] > bage_q));
	assign end_w = {1'b0, clock_q} + {17'd0, brem_q};
	assign fin = cmd.drain_mode ? (end_w[32] ? 32'hFFFF_FFFF : end_w[31:0]) : end_w[31:0];
	assign ta = (fin >= arr_q[best_q]) ? fin - arr_q[best_q] : 32'd0;
	assign sum_n = {1'b0, sum_q} + {17'd0, ta};
	assign sum_sat = sum_n[48] ? srtf_pkg::SUM_MAX : sum_n[47:0];
	assign cnt_inc = (cnt_q != srtf_pkg::CNT_MAX) ? cnt_q + 16'd1 : cnt_q;

	always_comb begin
		free_idx = '0;
		has_free = 1'b0;
		for (int i = D - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = W'(i);
				has_free = 1'b1;
			end
		end
	end

	assign sts.is_end = (in_q.command == srtf_pkg::CMD_END);
	assign sts.started = started_q;
	assign sts.scan_done = (scan_q == (W+1)'(D));
	assign sts.found = found_q;
	assign sts.before_arrival = clock_q < arr_eff_q;
	assign sts.ends_by_arrival = end_w <= {1'b0, arr_eff_q};
	assign sts.any_valid = |valid_q;
	assign sts.out_busy = out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			clock_q <= '0;
			started_q <= 1'b0;
			sum_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			scan_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				in_q <= in_word;
				arr_eff_q <= in_word.arrive_time;
			end
			if (cmd.start_clock) begin
				clock_q <= in_q.arrive_time;
				started_q <= 1'b1;
			end
			if (cmd.clamp_arrival && in_q.arrive_time < clock_q)
				arr_eff_q <= clock_q;
			if (cmd.scan_clear) begin
				scan_q <= '0;
				found_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				if (better) begin
					found_q <= 1'b1;
					best_q <= sidx;
					brem_q <= rem_q[sidx];
					bage_q <= age_q[sidx];
				end
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.complete) begin
				valid_q[best_q] <= 1'b0;
				clock_q <= fin;
				sum_q <= sum_sat;
				cnt_q <= cnt_inc;
			end
			if (cmd.preempt) begin
				rem_q[best_q] <= brem_q - 16'(arr_eff_q - clock_q);
				clock_q <= arr_eff_q;
			end
			if (cmd.jump_clock)
				clock_q <= arr_eff_q;
			if (cmd.insert) begin
				if (has_free) begin
					for (int i = 0; i < D; i++)
						if (valid_q[i] && age_q[i] != 16'hFFFF)
							age_q[i] <= age_q[i] + 16'd1;
					id_q[free_idx] <= in_q.job_id;
					arr_q[free_idx] <= arr_eff_q;
					rem_q[free_idx] <= in_q.burst;
					age_q[free_idx] <= '0;
					valid_q[free_idx] <= 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.clear_all) begin
				valid_q <= '0;
				clock_q <= '0;
				started_q <= 1'b0;
				sum_q <= '0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (cmd.emit_summary) begin
			out_word.done_id = '0;
			out_word.finish_time = clock_q;
			out_word.turnaround = '0;
			out_word.is_summary = 1'b1;
			out_word.turnaround_sum = sum_q;
			out_word.jobs_done = cnt_q;
			out_word.overflow = ovf_q;
			out_word.last = 1'b1;
		end else begin
			out_word.done_id = id_q[best_q];
			out_word.finish_time = fin;
			out_word.turnaround = ta;
			out_word.is_summary = 1'b0;
			out_word.turnaround_sum = sum_sat;
			out_word.jobs_done = cnt_inc;
			out_word.overflow = ovf_q;
			out_word.last = 1'b0;
		end
	end
endmodule

### design/srtf_ctrl.sv
`timescale 1ns / 1ps
module srtf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  srtf_pkg::dp_sts_t sts,
	output srtf_pkg::dp_cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_DEC  = 3'd3;
	localparam logic [2:0] S_SUMM = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_n;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_n = S_PREP;
				end
			end
			S_PREP: begin
				cmd.scan_clear = 1'b1;
				if (sts.is_end) begin
					state_n = S_SCAN;
				end else if (!sts.started) begin
					cmd.start_clock = 1'b1;
					state_n = S_SCAN;
				end else begin
					cmd.clamp_arrival = 1'b1;
					state_n = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_done)
					state_n = S_DEC;
				else
					cmd.scan_step = 1'b1;
			end
			S_DEC: begin
				cmd.drain_mode = sts.is_end;
				if (sts.is_end) begin
					if (sts.found) begin
						if (!sts.out_busy) begin
							cmd.complete = 1'b1;
							cmd.emit_job = 1'b1;
							cmd.scan_clear = 1'b1;
							state_n = S_SCAN;
						end
					end else begin
						state_n = S_SUMM;
					end
				end else if (sts.before_arrival && sts.found && sts.ends_by_arrival) begin
					if (!sts.out_busy) begin
						cmd.complete = 1'b1;
						cmd.emit_job = 1'b1;
						cmd.scan_clear = 1'b1;
						state_n = S_SCAN;
					end
				end else if (!sts.out_busy) begin
					if (sts.before_arrival) begin
						if (sts.found)
							cmd.preempt = 1'b1;
						else
							cmd.jump_clock = 1'b1;
					end
					cmd.insert = 1'b1;
					cmd.emit_last = 1'b1;
					state_n = S_IDLE;
				end
			end
			S_SUMM: begin
				if (!sts.out_busy) begin
					cmd.emit_summary = 1'b1;
					cmd.clear_all = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end
endmodule

### design/srtf_outq.sv
`timescale 1ns / 1ps
module srtf_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  srtf_pkg::out_word_t wr_word,
	input  logic                wr_valid,
	input  logic                wr_defer,
	input  logic                flush,
	output logic                wr_full,
	output srtf_pkg::out_word_t rd_word,
	output logic                rd_valid,
	input  logic                rd_stall
);
	srtf_pkg::out_word_t hold_q;
	logic                hv_q;
	srtf_pkg::out_word_t pb_q;
	logic                pv_q;
	srtf_pkg::out_word_t pb_fin;

	// a job word waits here until it is known whether it is the final one
	always_comb begin
		pb_fin = pb_q;
		pb_fin.last = 1'b1;
	end

	assign wr_full = hv_q && rd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q <= 1'b0;
			pv_q <= 1'b0;
		end else begin
			if (wr_valid && !wr_defer) begin
				hold_q <= wr_word;
				hv_q <= 1'b1;
			end else if (wr_valid && pv_q) begin
				hold_q <= pb_q;
				hv_q <= 1'b1;
			end else if (flush && pv_q) begin
				hold_q <= pb_fin;
				hv_q <= 1'b1;
			end else if (!rd_stall) begin
				hv_q <= 1'b0;
			end
			if (wr_valid && wr_defer) begin
				pb_q <= wr_word;
				pv_q <= 1'b1;
			end else if (flush) begin
				pv_q <= 1'b0;
			end
		end
	end
	assign rd_word = hold_q;
	assign rd_valid = hv_q;
endmodule

### design/preemptive_srtf_scheduler.sv
`timescale 1ns / 1ps
// Flow: the input stays stalled through prep, a queue scan and the decision, so a
// new word is taken only after the last one is done; each completion adds a rescan,
// and an end word adds a summary step. Output: a job result reaches the port at the
// next decision (completion or insert) of the same input, or at once while an end
// word drains; a stalled output holds every decision.
// Reset: asynchronous, active low; clears valid bits, clock, sum, count and flags.
module preemptive_srtf_scheduler (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  srtf_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output srtf_pkg::out_word_t out_word
);
	srtf_pkg::dp_cmd_t   cmd;
	srtf_pkg::dp_sts_t   sts;
	srtf_pkg::out_word_t dp_word;
	logic                oq_full;

	srtf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sts(sts), .cmd(cmd)
	);

	srtf_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_word(in_word), .cmd(cmd), .sts(sts),
		.out_word(dp_word), .out_busy(oq_full)
	);

	srtf_outq u_oq (
		.clk(clk), .arst_n(arst_n), .wr_word(dp_word),
		.wr_valid(cmd.emit_job || cmd.emit_summary),
		.wr_defer(cmd.emit_job && !cmd.drain_mode), .flush(cmd.emit_last),
		.wr_full(oq_full), .rd_word(out_word), .rd_valid(out_valid), .rd_stall(out_stall)
	);
endmodule

### design/srtf_checker.sv
`timescale 1ns / 1ps
module srtf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input srtf_pkg::out_word_t out_word
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("output word changed under stall");
	a_summary_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.is_summary |-> out_word.done_id == 16'd0 && out_word.last)
		else $error("summary word malformed");
	a_summary_ta: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.is_summary |-> out_word.turnaround == 32'd0)
		else $error("summary turnaround nonzero");
	a_job_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.is_summary |-> out_word.jobs_done != 16'd0)
		else $error("completed job with zero count");
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");
endmodule

bind preemptive_srtf_scheduler srtf_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
);
